[design/f16acc_pkg.sv]
// Package: shared types and helpers for the fp16-into-fp32 accumulate pipeline
`default_nettype none
package f16acc_pkg;
    localparam int unsigned DataWidth = 48;
    localparam int unsigned SumWidth  = 32;
    localparam logic [31:0] DefaultNan = 32'h7FC0_0000;
    localparam logic [31:0] QuietBit   = 32'h0040_0000;

    // Stage 1 to stage 2: aligned operands
    typedef struct packed {
        logic        special;
        logic [31:0] special_val;
        logic        sign;
        logic        sub;
        logic [7:0]  exp;
        logic [31:0] ma;
        logic [31:0] mb;
        logic        last;
    } align_t;

    // Stage 2 to stage 3: raw sum
    typedef struct packed {
        logic        special;
        logic [31:0] special_val;
        logic        sign;
        logic        zero;
        logic [8:0]  exp;
        logic [31:0] sum;
        logic        last;
    } addr_t;

    typedef struct packed {
        logic [31:0] sum_bits;
        logic        last;
    } res_t;

    // Leading-zero count of a 32-bit word
    function automatic logic [5:0] lzc32(input logic [31:0] v);
        logic [5:0] n;
        logic       found;
        n = 6'd32;
        found = 1'b0;
        for (int i = 31; i >= 0; i--) begin
            if (!found && v[i]) begin
                n = 6'(31 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction
endpackage
`default_nettype wire

[design/f16acc_align.sv]
// Stage 1: widen the half operand, resolve special cases, align the mantissas
`default_nettype none
module f16acc_align (
    input  wire logic [31:0]      acc,
    input  wire logic [15:0]      half,
    input  wire logic             last,
    output f16acc_pkg::align_t    aln
);
    import f16acc_pkg::*;

    logic [31:0] b_w, a, b;
    logic [5:0]  hz;
    logic [9:0]  hm;
    logic        a_nan, b_nan, a_inf, b_inf, swap;
    logic [7:0]  ea, eb, d;
    logic [31:0] ma, mb, shifted, lostmask;

    always_comb begin
        hz = lzc32({22'd0, half[9:0]}) - 6'd22;
        hm = 10'(half[9:0] << (hz + 6'd1));
        if (half[14:10] == 5'h1F) begin
            b_w = {half[15], 8'hFF, half[9:0], 13'd0};
        end else if (half[14:10] == 5'd0) begin
            if (half[9:0] == 10'd0) begin
                b_w = {half[15], 31'd0};
            end else begin
                b_w = {half[15], 8'(8'd112 - {2'd0, hz}), hm, 13'd0};
            end
        end else begin
            b_w = {half[15], 8'({3'd0, half[14:10]} + 8'd112), half[9:0], 13'd0};
        end
        a_nan = (acc[30:23] == 8'hFF) && (acc[22:0] != 23'd0);
        b_nan = (b_w[30:23] == 8'hFF) && (b_w[22:0] != 23'd0);
        a_inf = acc[30:0] == 31'h7F80_0000;
        b_inf = b_w[30:0] == 31'h7F80_0000;
        swap  = b_w[30:0] > acc[30:0];
        a = swap ? b_w : acc;
        b = swap ? acc : b_w;
        ea = (a[30:23] != 8'd0) ? a[30:23] : 8'd1;
        eb = (b[30:23] != 8'd0) ? b[30:23] : 8'd1;
        ma = {1'b0, a[30:23] != 8'd0, a[22:0], 7'd0};
        mb = {1'b0, b[30:23] != 8'd0, b[22:0], 7'd0};
        d  = ea - eb;
        lostmask = (32'd1 << d[4:0]) - 32'd1;
        if (d >= 8'd32) begin
            shifted = {31'd0, mb != 32'd0};
        end else begin
            shifted  = (mb >> d[4:0]) | {31'd0, (mb & lostmask) != 32'd0};
        end
        aln.special = a_nan || b_nan || a_inf || b_inf;
        if (a_nan)
            aln.special_val = acc | QuietBit;
        else if (b_nan)
            aln.special_val = b_w | QuietBit;
        else if (a_inf && b_inf && (acc[31] != b_w[31]))
            aln.special_val = DefaultNan;
        else if (a_inf)
            aln.special_val = acc;
        else
            aln.special_val = b_w;
        aln.sign = a[31];
        aln.sub  = a[31] != b[31];
        aln.exp  = ea;
        aln.ma   = ma;
        aln.mb   = shifted;
        aln.last = last;
    end
endmodule
`default_nettype wire

[design/f16acc_add.sv]
// Stage 2: add or subtract the aligned mantissas
`default_nettype none
module f16acc_add (
    input  wire f16acc_pkg::align_t aln,
    output f16acc_pkg::addr_t       add
);
    import f16acc_pkg::*;

    logic [31:0] s;

    always_comb begin
        s = aln.sub ? (aln.ma - aln.mb) : (aln.ma + aln.mb);
        add.special     = aln.special;
        add.special_val = aln.special_val;
        add.zero        = s == 32'd0;
        add.sign        = (s == 32'd0) ? (aln.sign && !aln.sub) : aln.sign;
        add.exp         = {1'b0, aln.exp};
        add.sum         = s;
        add.last        = aln.last;
    end
endmodule
`default_nettype wire

[design/f16acc_round.sv]
// Stage 3: normalise, round to nearest even and pack the result
`default_nettype none
module f16acc_round (
    input  wire f16acc_pkg::addr_t add,
    output f16acc_pkg::res_t       res
);
    import f16acc_pkg::*;

    logic [5:0]  lz, sh;
    logic [31:0] n;
    logic [8:0]  e;
    logic [6:0]  rem;
    logic [24:0] m;

    always_comb begin
        lz = lzc32(add.sum);
        n  = add.sum;
        e  = add.exp;
        sh = 6'd0;
        if (add.sum[31]) begin
            n = {1'b0, add.sum[31:2], add.sum[1] | add.sum[0]};
            e = add.exp + 9'd1;
        end else if (lz > 6'd1) begin
            sh = ((add.exp - 9'd1) < {3'd0, lz - 6'd1}) ? 6'(add.exp - 9'd1) : lz - 6'd1;
            n  = add.sum << sh;
            e  = add.exp - {3'd0, sh};
        end
        rem = n[6:0];
        m   = {1'b0, n[30:7]};
        if (rem > 7'h40 || (rem == 7'h40 && m[0]))
            m = m + 25'd1;
        if (m[24]) begin
            m = m >> 1;
            e = e + 9'd1;
        end
        res.last = add.last;
        if (add.special)
            res.sum_bits = add.special_val;
        else if (add.zero)
            res.sum_bits = {add.sign, 31'd0};
        else if (e >= 9'd255)
            res.sum_bits = {add.sign, 8'hFF, 23'd0};
        else
            res.sum_bits = {add.sign, m[23] ? e[7:0] : 8'd0, m[22:0]};
    end
endmodule
`default_nettype wire

[design/fp16_accumulate_into_fp32.sv]
// Top level: three-stage fp16-widen and fp32-add stream pipeline
// Path: an input transaction is registered in aln_reg, add_reg and res_reg in turn; res_reg drives m_tdata.
// Throughput: one transaction per cycle while m_tready holds; each stage advances when the next is free.
// Output register acts as the final stage; a stall holds each full stage with no empty stage ahead of it.
// Reset: aresetn (synchronous, active low) clears all stage valid bits.
`default_nettype none
module fp16_accumulate_into_fp32 (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [31:0] accumulator_bits, [47:32] addend_bits
    input  wire logic [f16acc_pkg::DataWidth-1:0] s_tdata,
    input  wire logic                            s_tlast,  // last_element
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [f16acc_pkg::SumWidth-1:0]      m_tdata,  // [31:0] sum_bits
    output logic                                 m_tlast   // last_out
);
    import f16acc_pkg::*;

    align_t aln_next, aln_reg;
    addr_t  add_next, add_reg;
    res_t   res_next, res_reg;
    logic   v1_reg, v2_reg, v3_reg;
    logic   adv1, adv2, adv3;

    f16acc_align u_align (.acc(s_tdata[31:0]), .half(s_tdata[47:32]), .last(s_tlast),
                          .aln(aln_next));
    f16acc_add   u_add   (.aln(aln_reg), .add(add_next));
    f16acc_round u_round (.add(add_reg), .res(res_next));

    // Each stage advances when the stage ahead is empty or moving
    assign adv3     = !v3_reg || m_tready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign s_tready = adv1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_tvalid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) aln_reg <= aln_next;
        if (adv2) add_reg <= add_next;
        if (adv3) res_reg <= res_next;
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = res_reg.sum_bits;
    assign m_tlast  = res_reg.last;

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");
    // A full pipe under stall refuses input
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg && v2_reg && v3_reg && !m_tready |-> !s_tready)
        else $error("input accepted into full pipeline");
    // Stage 2 follows stage 1 when advancing
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        adv2 && v1_reg |=> v2_reg)
        else $error("item lost between stages");
endmodule
`default_nettype wire
